// ===== hdl/drrip_pkg.sv =====
`default_nettype none
package drrip_pkg;

  // Field widths fixed by the interface
  localparam int ACT_W    = 1;
  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int ADDR_W   = 64;

  // Request kinds
  localparam logic ACT_VICTIM = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // RRPV values
  localparam logic [1:0] RRPV_NEAR = 2'd0;
  localparam logic [1:0] RRPV_LONG = 2'd2;
  localparam logic [1:0] RRPV_MAX  = 2'd3;

  // Set dueling selector
  localparam int          PSEL_W         = 10;
  localparam logic [9:0]  PSEL_TOP       = 10'd1023;
  localparam logic [9:0]  PSEL_START     = 10'd512;
  localparam logic [9:0]  PSEL_THRESHOLD = 10'd511;

  // BRRIP fill counter wraps at its width (mask 0x1F)
  localparam int FILL_W = 5;

  // Stream confidence
  localparam logic [1:0] CONF_MAX    = 2'd3;
  localparam logic [1:0] CONF_STREAM = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]        conf;
    logic [ADDR_W-1:0] stride;
    logic [ADDR_W-1:0] prev_addr;
  } stride_entry_t;

  typedef struct packed {
    logic       is_victim;
    logic [1:0] ins;
  } row_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/drrip_ram.sv =====
`default_nettype none
module drrip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hdl/drrip_stride_unit.sv =====
`default_nettype none
module drrip_stride_unit (
  input  wire drrip_pkg::stride_entry_t          ent,
  input  wire logic [drrip_pkg::ADDR_W-1:0]      addr,
  output drrip_pkg::stride_entry_t               ent_nxt,
  output logic                                   streaming
);

  logic [drrip_pkg::ADDR_W-1:0] stride;
  logic                         match;
  logic [1:0]                   conf_n;

  always_comb begin
    stride = addr - ent.prev_addr;
    match  = (ent.stride != '0) && (stride == ent.stride);
    if (match) begin
      conf_n = (ent.conf == drrip_pkg::CONF_MAX) ? ent.conf : ent.conf + 2'd1;
    end else begin
      conf_n = (ent.conf == 2'd0) ? ent.conf : ent.conf - 2'd1;
    end
    streaming         = (conf_n >= drrip_pkg::CONF_STREAM);
    ent_nxt.conf      = conf_n;
    ent_nxt.stride    = stride;
    ent_nxt.prev_addr = addr;
  end

endmodule
`default_nettype wire

// ===== hdl/drrip_rrpv_unit.sv =====
`default_nettype none
module drrip_rrpv_unit #(
  parameter int WAYS = 16,
  localparam int WW = $clog2(WAYS)
) (
  input  wire drrip_pkg::row_ctl_t                 ctl,
  input  wire logic [drrip_pkg::WAY_IN_W-1:0]      way,
  input  wire logic [2*WAYS-1:0]                   row,
  output logic      [2*WAYS-1:0]                   row_nxt,
  output logic      [WW-1:0]                       victim
);

  logic              hi_any;
  logic              lo_any;
  logic              both_any;
  logic [1:0]        top;
  logic [1:0]        add;
  logic [2*WAYS-1:0] aged;

  // Largest RRPV as an OR reduction over the row
  always_comb begin
    hi_any   = 1'b0;
    lo_any   = 1'b0;
    both_any = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hi_any   = hi_any | row[2*w+1];
      lo_any   = lo_any | row[2*w];
      both_any = both_any | (row[2*w+1] & row[2*w]);
    end
    top = hi_any ? {1'b1, both_any} : {1'b0, lo_any};
    add = drrip_pkg::RRPV_MAX - top;
  end

  always_comb begin
    victim = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      aged[2*w +: 2] = row[2*w +: 2] + add;
      if (aged[2*w +: 2] == drrip_pkg::RRPV_MAX) begin
        victim = WW'(w);
      end
    end
  end

  // Out-of-range way leaves the row untouched
  always_comb begin
    if (ctl.is_victim) begin
      row_nxt = aged;
    end else begin
      row_nxt = row;
      for (int w = 0; w < WAYS; w++) begin
        if (32'(way) == w) begin
          row_nxt[2*w +: 2] = ctl.ins;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/drrip_streaming_bypass_replacement.sv =====
`default_nettype none
// DRRIP replacement engine (2-bit RRPV) with a per-set stride detector that
// inserts streaming misses at distant RRPV. A request with action 0 is a victim
// query: the set is aged so some way holds RRPV 3, the aged row is written back
// and the lowest such way comes out on the result channel. Action 1 is an
// update (hit or fill) and gives no result. The RRPV rows (one row per set)
// and the stride entries (last address, last stride, confidence) sit in two
// synchronous RAMs with registered reads. Each request first reads both RAMs at
// the set, then modifies and writes back; a new request is accepted only after
// that single read/write pass for the last one ends. A victim query whose
// result finds the previous result still held waits in the write-back state
// until the output register frees. After reset a clearing pass writes every
// set (2048 by default), during which in_stall stays high. set_index is
// reduced modulo SETS.
module drrip_streaming_bypass_replacement #(
  parameter int SETS          = 2048,
  parameter int WAYS          = 16,
  parameter int SRRIP_LEADERS = 32,
  parameter int BRRIP_LEADERS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [drrip_pkg::ACT_W-1:0]        in_action,
  input  wire logic [drrip_pkg::SET_IN_W-1:0]     in_set_index,
  input  wire logic [drrip_pkg::WAY_IN_W-1:0]     in_way_index,
  input  wire logic [drrip_pkg::ADDR_W-1:0]       in_address,
  input  wire logic                               in_hit,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [drrip_pkg::WAY_IN_W-1:0]     out_victim_way
);

  localparam int SW        = $clog2(SETS);
  localparam int WW        = $clog2(WAYS);
  localparam int ROW_W     = 2 * WAYS;
  localparam int ENT_W     = $bits(drrip_pkg::stride_entry_t);
  localparam int SI_W      = drrip_pkg::SET_IN_W;
  localparam int VW        = drrip_pkg::WAY_IN_W;
  localparam int FW        = drrip_pkg::FILL_W;
  localparam int PW        = drrip_pkg::PSEL_W;
  // set_index < 2048 and SETS >= 64: quotient fits in 5 bits
  localparam int MOD_STEPS = 5;

  drrip_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]                   clr_cnt_r;
  logic                            act_r;
  logic [VW-1:0]                   way_r;
  logic [drrip_pkg::ADDR_W-1:0]    addr_r;
  logic                            hit_r;
  logic [SW-1:0]                   set_r;
  logic [drrip_pkg::PSEL_W-1:0]    psel_r, psel_nxt;
  logic [drrip_pkg::FILL_W-1:0]    fill_r, fill_nxt;
  logic                            out_valid_r;
  logic [VW-1:0]                   out_victim_r;

  logic                            in_accept;
  logic                            can_out;
  logic                            exec_go;
  logic [SI_W-1:0]                 set_rem;
  logic [SW-1:0]                   set_mod;

  // RAM ports
  logic                            rd_en;
  logic                            row_wr_en;
  logic                            ent_wr_en;
  logic [SW-1:0]                   wr_addr;
  logic [ROW_W-1:0]                row_rd, row_new, row_wr;
  drrip_pkg::stride_entry_t        ent_rd, ent_new, ent_wr;

  logic                            streaming;
  logic [WW-1:0]                   victim;
  drrip_pkg::row_ctl_t             row_ctl;

  logic                            srrip_lead;
  logic                            brrip_lead;
  logic                            pick_srrip;
  logic                            policy_miss;
  logic [1:0]                      ins_val;

  assign in_accept = in_valid && !in_stall;
  assign can_out   = !out_valid_r || !out_stall;
  assign exec_go   = (state_r == drrip_pkg::ST_EXEC) &&
                     ((act_r == drrip_pkg::ACT_UPDATE) || can_out);

  // set_index mod SETS by restoring subtraction
  always_comb begin
    set_rem = in_set_index;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (32'(set_rem) >= (32'(SETS) << k)) begin
        set_rem = set_rem - SI_W'(32'(SETS) << k);
      end
    end
    set_mod = SW'(set_rem);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      drrip_pkg::ST_CLEAR: begin
        if (clr_cnt_r == SW'(SETS - 1)) state_nxt = drrip_pkg::ST_IDLE;
      end
      drrip_pkg::ST_IDLE: begin
        if (in_accept) state_nxt = drrip_pkg::ST_EXEC;
      end
      drrip_pkg::ST_EXEC: begin
        if (exec_go) state_nxt = drrip_pkg::ST_IDLE;
      end
      default: state_nxt = drrip_pkg::ST_CLEAR;
    endcase
  end

  // state outputs: handshake and RAM strobes
  always_comb begin
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    row_wr_en = 1'b0;
    ent_wr_en = 1'b0;
    wr_addr   = set_r;
    row_wr    = row_new;
    ent_wr    = ent_new;
    case (state_r)
      drrip_pkg::ST_CLEAR: begin
        row_wr_en = 1'b1;
        ent_wr_en = 1'b1;
        wr_addr   = clr_cnt_r;
        row_wr    = {WAYS{drrip_pkg::RRPV_MAX}};
        ent_wr    = '0;
      end
      drrip_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid;
      end
      drrip_pkg::ST_EXEC: begin
        row_wr_en = exec_go;
        ent_wr_en = exec_go && (act_r == drrip_pkg::ACT_UPDATE);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  drrip_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_rrpv_ram (
    .clk     (clk),
    .wr_en   (row_wr_en),
    .wr_addr (wr_addr),
    .wr_data (row_wr),
    .rd_en   (rd_en),
    .rd_addr (set_mod),
    .rd_data (row_rd)
  );

  drrip_ram #(.WIDTH(ENT_W), .DEPTH(SETS)) u_stride_ram (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (wr_addr),
    .wr_data (ent_wr),
    .rd_en   (rd_en),
    .rd_addr (set_mod),
    .rd_data (ent_rd)
  );

  drrip_stride_unit u_stride (
    .ent       (ent_rd),
    .addr      (addr_r),
    .ent_nxt   (ent_new),
    .streaming (streaming)
  );

  // insertion policy and set dueling
  always_comb begin
    srrip_lead  = 32'(set_r) < SRRIP_LEADERS;
    brrip_lead  = !srrip_lead && (32'(set_r) < (SRRIP_LEADERS + BRRIP_LEADERS));
    pick_srrip  = srrip_lead ||
                  (!brrip_lead && (psel_r >= drrip_pkg::PSEL_THRESHOLD));
    policy_miss = exec_go && (act_r == drrip_pkg::ACT_UPDATE) && !hit_r && !streaming;

    fill_nxt = fill_r;
    psel_nxt = psel_r;
    if (policy_miss) begin
      if (!pick_srrip) fill_nxt = fill_r + FW'(1);
      if (srrip_lead) begin
        if (psel_r != '0) psel_nxt = psel_r - PW'(1);
      end else if (brrip_lead) begin
        if (psel_r != drrip_pkg::PSEL_TOP) psel_nxt = psel_r + PW'(1);
      end
    end

    if (hit_r) begin
      ins_val = drrip_pkg::RRPV_NEAR;
    end else if (streaming) begin
      ins_val = drrip_pkg::RRPV_MAX;
    end else if (pick_srrip) begin
      ins_val = drrip_pkg::RRPV_LONG;
    end else begin
      // every 32nd BRRIP fill goes in at distant
      ins_val = (fill_nxt == '0) ? drrip_pkg::RRPV_MAX : drrip_pkg::RRPV_LONG;
    end

    row_ctl.is_victim = (act_r == drrip_pkg::ACT_VICTIM);
    row_ctl.ins       = ins_val;
  end

  drrip_rrpv_unit #(.WAYS(WAYS)) u_rrpv (
    .ctl     (row_ctl),
    .way     (way_r),
    .row     (row_rd),
    .row_nxt (row_new),
    .victim  (victim)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drrip_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      psel_r      <= drrip_pkg::PSEL_START;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == drrip_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + SW'(1);
      psel_r <= psel_nxt;
      fill_r <= fill_nxt;
      if (exec_go && (act_r == drrip_pkg::ACT_VICTIM)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r  <= in_action;
      way_r  <= in_way_index;
      addr_r <= in_address;
      hit_r  <= in_hit;
      set_r  <= set_mod;
    end
    if (exec_go && (act_r == drrip_pkg::ACT_VICTIM)) begin
      out_victim_r <= VW'(victim);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_victim_way = out_victim_r;

endmodule
`default_nettype wire
